>>> src/cube_map_face_select_macros.svh
// Assertion macros shared by the cube map face select RTL.
// Set ASSERT_OFF to compile them out.
`ifndef CUBE_MAP_FACE_SELECT_MACROS_SVH
`define CUBE_MAP_FACE_SELECT_MACROS_SVH

`ifndef ASSERT_OFF
`define CMFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmfs assertion failed");
`define CMFS_ASSERT_SEQ(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("cmfs sequence assertion failed");
`else
`define CMFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CMFS_ASSERT_SEQ(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/cmfs_pkg.sv
package cmfs_pkg;

    localparam int DIR_W       = 16;
    localparam int MAG_W       = 17;
    localparam int FACE_W      = 3;
    localparam int FACE_SIZE_W = 11;
    localparam int TEXEL_W     = 10;
    localparam int INDEX_W     = 20;

    localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RST = 11'd256;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } t_dir;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic [INDEX_W-1:0] texel_index;
        logic               zero_direction;
    } t_result;

    // face and zero flag carried alongside the division
    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              zero;
    } t_tag;

    typedef struct packed {
        t_tag                    tag;
        logic [MAG_W-1:0]        m;
        logic signed [MAG_W-1:0] s;
        logic signed [MAG_W-1:0] t;
    } t_sel;

endpackage

>>> src/cube_map_face_select.sv
// Cube map face select. One request is taken every clock cycle (busy never rises) and its
// result appears on o_result with o_result_valid after the select register, the scale
// register, the texel divider stages, the clamp register and the output register; the texel
// divider resolves one quotient bit per pipeline stage for both texel axes at once.
// Results are in request order and must be taken in the cycle they are shown. The face
// size register may only be written while no request is in flight.
`include "cube_map_face_select_macros.svh"

module cube_map_face_select import cmfs_pkg::*; #(
    parameter int MAX_FACE_SIZE = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_dir                   i_dir,
    output logic                   o_result_valid,
    output t_result                o_result,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [FACE_SIZE_W-1:0] i_cfg_data
);

    localparam int SW  = $clog2(MAX_FACE_SIZE + 1);
    localparam int NW  = MAG_W + SW;
    localparam int DW  = MAG_W;
    localparam int IW  = (2 * SW + 1 > INDEX_W) ? 2 * SW + 1 : INDEX_W;
    localparam int TW  = (SW > TEXEL_W) ? SW : TEXEL_W;
    localparam int LAT = SW + 4;

    logic [FACE_SIZE_W-1:0] r_face_size;
    logic [SW-1:0]          w_size, w_size_m1;

    logic                   a_vld;
    t_sel                   a_sel;

    logic [MAG_W:0]         sum_s, sum_t;
    logic                   r_b_vld;
    logic [NW-1:0]          r_b_num_s, r_b_num_t;
    logic [DW-1:0]          r_b_den;
    t_tag                   r_b_tag;

    logic                   c_vld;
    logic [SW-1:0]          c_q_s, c_q_t;
    t_tag                   c_tag;

    logic [SW-1:0]          n_d_tx, n_d_ty;
    logic                   r_d_vld;
    logic [SW-1:0]          r_d_tx;
    logic [IW-1:0]          r_d_prod;
    logic [SW-1:0]          r_d_ty;
    t_tag                   r_d_tag;

    logic [TW-1:0]          ext_tx, ext_ty;
    logic [IW-1:0]          idx_sum;
    t_result                n_out;
    logic                   r_out_vld;
    t_result                r_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size <= FACE_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_face_size <= i_cfg_data;
        end
    end

    always_comb begin
        priority if (r_face_size == '0) begin
            w_size = SW'(1);
        end else if (int'(r_face_size) > MAX_FACE_SIZE) begin
            w_size = SW'(MAX_FACE_SIZE);
        end else begin
            w_size = SW'(r_face_size);
        end
    end
    assign w_size_m1 = w_size - SW'(1);

    cmfs_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_dir   (i_dir),
        .o_vld   (a_vld),
        .o_sel   (a_sel)
    );

    // offset minor components into 0..2m and scale by the face size
    assign sum_s = {a_sel.s[MAG_W-1], a_sel.s} + {1'b0, a_sel.m};
    assign sum_t = {a_sel.t[MAG_W-1], a_sel.t} + {1'b0, a_sel.m};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_num_s <= NW'(sum_s[MAG_W-1:0]) * NW'(w_size);
        r_b_num_t <= NW'(sum_t[MAG_W-1:0]) * NW'(w_size);
        r_b_den   <= {a_sel.m[DW-2:0], 1'b0};
        r_b_tag   <= a_sel.tag;
    end

    cmfs_divider #(
        .NW (NW),
        .DW (DW),
        .QW (SW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_num_s (r_b_num_s),
        .i_num_t (r_b_num_t),
        .i_den   (r_b_den),
        .i_tag   (r_b_tag),
        .o_vld   (c_vld),
        .o_q_s   (c_q_s),
        .o_q_t   (c_q_t),
        .o_tag   (c_tag)
    );

    assign n_d_tx = (c_q_s > w_size_m1) ? w_size_m1 : c_q_s;
    assign n_d_ty = (c_q_t > w_size_m1) ? w_size_m1 : c_q_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_tx   <= n_d_tx;
        r_d_ty   <= n_d_ty;
        r_d_prod <= IW'(n_d_ty) * IW'(w_size);
        r_d_tag  <= c_tag;
    end

    assign ext_tx  = TW'(r_d_tx);
    assign ext_ty  = TW'(r_d_ty);
    assign idx_sum = r_d_prod + IW'(r_d_tx);

    always_comb begin
        n_out = '0;
        n_out.zero_direction = r_d_tag.zero;
        if (!r_d_tag.zero) begin
            n_out.face        = r_d_tag.face;
            n_out.texel_x     = ext_tx[TEXEL_W-1:0];
            n_out.texel_y     = ext_ty[TEXEL_W-1:0];
            n_out.texel_index = idx_sum[INDEX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    `CMFS_ASSERT_SEQ(a_latency, i_clk, i_rst_n, start && !busy, ##LAT o_result_valid)
    `CMFS_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_result_valid, $past(start && !busy, LAT))
    `CMFS_ASSERT_IMP(a_face_code, i_clk, i_rst_n, o_result_valid, o_result.face <= FACE_NEG_Z)
    `CMFS_ASSERT_IMP(a_texel_range, i_clk, i_rst_n,
        o_result_valid && !o_result.zero_direction,
        (32'(o_result.texel_x) < 32'(w_size)) && (32'(o_result.texel_y) < 32'(w_size)))

endmodule

>>> src/cmfs_select.sv
module cmfs_select import cmfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_dir i_dir,
    output logic o_vld,
    output t_sel o_sel
);

    logic signed [MAG_W-1:0] xe, ye, ze;
    logic signed [MAG_W-1:0] nx, ny, nz;
    logic [MAG_W-1:0]        ax, ay, az;
    t_sel                    n_sel;
    logic                    r_vld;
    t_sel                    r_sel;

    assign xe = {i_dir.dir_x[DIR_W-1], i_dir.dir_x};
    assign ye = {i_dir.dir_y[DIR_W-1], i_dir.dir_y};
    assign ze = {i_dir.dir_z[DIR_W-1], i_dir.dir_z};
    assign nx = -xe;
    assign ny = -ye;
    assign nz = -ze;
    assign ax = xe[MAG_W-1] ? nx : xe;
    assign ay = ye[MAG_W-1] ? ny : ye;
    assign az = ze[MAG_W-1] ? nz : ze;

    always_comb begin
        n_sel          = '0;
        n_sel.tag.zero = (ax == '0) && (ay == '0) && (az == '0);
        priority if ((ax >= ay) && (ax >= az)) begin
            n_sel.m = ax;
            n_sel.t = ny;
            if (!xe[MAG_W-1] && (xe != '0)) begin
                n_sel.tag.face = FACE_POS_X;
                n_sel.s        = nz;
            end else begin
                n_sel.tag.face = FACE_NEG_X;
                n_sel.s        = ze;
            end
        end else if (ay >= az) begin
            n_sel.m = ay;
            n_sel.s = xe;
            if (!ye[MAG_W-1] && (ye != '0)) begin
                n_sel.tag.face = FACE_POS_Y;
                n_sel.t        = ze;
            end else begin
                n_sel.tag.face = FACE_NEG_Y;
                n_sel.t        = nz;
            end
        end else begin
            n_sel.m = az;
            n_sel.t = ny;
            if (!ze[MAG_W-1] && (ze != '0)) begin
                n_sel.tag.face = FACE_POS_Z;
                n_sel.s        = xe;
            end else begin
                n_sel.tag.face = FACE_NEG_Z;
                n_sel.s        = nx;
            end
        end
        if (n_sel.tag.zero) begin
            n_sel.tag.face = FACE_POS_X;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
    end

    assign o_vld = r_vld;
    assign o_sel = r_sel;

endmodule

>>> src/cmfs_divider.sv
module cmfs_divider import cmfs_pkg::*; #(
    parameter int NW = 28,
    parameter int DW = 17,
    parameter int QW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num_s,
    input  logic [NW-1:0] i_num_t,
    input  logic [DW-1:0] i_den,
    input  t_tag          i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_q_s,
    output logic [QW-1:0] o_q_t,
    output t_tag          o_tag
);

    // one quotient bit per stage, most significant first
    logic [NW-1:0] w_rs  [QW];
    logic [NW-1:0] w_rt  [QW];
    logic [DW-1:0] w_den [QW];
    logic [QW-1:0] w_qs  [QW+1];
    logic [QW-1:0] w_qt  [QW+1];
    t_tag          w_tag [QW+1];
    logic [QW:0]   w_vld;

    assign w_rs[0]  = i_num_s;
    assign w_rt[0]  = i_num_t;
    assign w_den[0] = i_den;
    assign w_qs[0]  = '0;
    assign w_qt[0]  = '0;
    assign w_tag[0] = i_tag;
    assign w_vld[0] = i_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stg
        localparam int B = QW - 1 - k;

        logic [NW-1:0] dsh;
        logic          bit_s, bit_t;
        logic [QW-1:0] n_qs, n_qt;
        logic          r_vld;
        logic [QW-1:0] r_qs, r_qt;
        t_tag          r_tag;

        assign dsh   = NW'(w_den[k]) << B;
        assign bit_s = w_rs[k] >= dsh;
        assign bit_t = w_rt[k] >= dsh;
        assign n_qs  = w_qs[k] | (QW'(bit_s) << B);
        assign n_qt  = w_qt[k] | (QW'(bit_t) << B);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_qs  <= n_qs;
            r_qt  <= n_qt;
            r_tag <= w_tag[k];
        end

        assign w_vld[k+1] = r_vld;
        assign w_qs[k+1]  = r_qs;
        assign w_qt[k+1]  = r_qt;
        assign w_tag[k+1] = r_tag;

        if (k < QW - 1) begin : g_rem
            logic [NW-1:0] r_rs, r_rt;
            logic [DW-1:0] r_den;

            always_ff @(posedge i_clk) begin
                r_rs  <= bit_s ? (w_rs[k] - dsh) : w_rs[k];
                r_rt  <= bit_t ? (w_rt[k] - dsh) : w_rt[k];
                r_den <= w_den[k];
            end

            assign w_rs[k+1]  = r_rs;
            assign w_rt[k+1]  = r_rt;
            assign w_den[k+1] = r_den;
        end
    end

    assign o_vld = w_vld[QW];
    assign o_q_s = w_qs[QW];
    assign o_q_t = w_qt[QW];
    assign o_tag = w_tag[QW];

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import cmfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIZE   = 1024;
    localparam int LATENCY    = 15;
    localparam int DRAIN      = LATENCY + 8;
    localparam int IDLE_LIMIT = 2000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_dir                   i_dir = '0;
    logic                   o_result_valid;
    t_result                o_result;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [FACE_SIZE_W-1:0] i_cfg_data = '0;

    t_result                expected_texels[$];
    logic [FACE_SIZE_W-1:0] face_size_model = FACE_SIZE_RST;
    int                     error_count = 0;
    int                     idle_cycles = 0;
    bit                     accepted_now;
    bit                     burst_mode = 0;

    cube_map_face_select dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_dir          (i_dir),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int axis_texel(int c, int m, int size);
        longint num;
        longint q;
        num = longint'(c + m) * longint'(size);
        q   = num / (2 * longint'(m));
        if (q > size - 1) q = size - 1;
        return int'(q);
    endfunction

    function automatic t_result predict_texel(t_dir d, logic [FACE_SIZE_W-1:0] size_reg);
        t_result r;
        int x, y, z, ax, ay, az, m, s, t, size, tx, ty;
        r    = '0;
        x    = int'(d.dir_x);
        y    = int'(d.dir_y);
        z    = int'(d.dir_z);
        ax   = (x < 0) ? -x : x;
        ay   = (y < 0) ? -y : y;
        az   = (z < 0) ? -z : z;
        size = int'(size_reg);
        if (size < 1) size = 1;
        if (size > MAX_SIZE) size = MAX_SIZE;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.zero_direction = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az) begin
            m = ax;
            if (x > 0) begin
                r.face = FACE_POS_X; s = -z; t = -y;
            end else begin
                r.face = FACE_NEG_X; s = z; t = -y;
            end
        end else if (ay >= az) begin
            m = ay;
            if (y > 0) begin
                r.face = FACE_POS_Y; s = x; t = z;
            end else begin
                r.face = FACE_NEG_Y; s = x; t = -z;
            end
        end else begin
            m = az;
            if (z > 0) begin
                r.face = FACE_POS_Z; s = x; t = -y;
            end else begin
                r.face = FACE_NEG_Z; s = -x; t = -y;
            end
        end
        tx = axis_texel(s, m, size);
        ty = axis_texel(t, m, size);
        r.texel_x     = TEXEL_W'(tx);
        r.texel_y     = TEXEL_W'(ty);
        r.texel_index = INDEX_W'(ty * size + tx);
        return r;
    endfunction

    // request/result monitor and checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            accepted_now = 0;
            if (o_result_valid) begin
                accepted_now = 1;
                if (expected_texels.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_result);
                    error_count++;
                end else begin
                    t_result exp_r;
                    exp_r = expected_texels.pop_front();
                    if (o_result.face !== exp_r.face) begin
                        $display("%0t: face expected %0d actual %0d",
                                 $time, exp_r.face, o_result.face);
                        error_count++;
                    end
                    if (o_result.texel_x !== exp_r.texel_x) begin
                        $display("%0t: texel_x expected %0d actual %0d",
                                 $time, exp_r.texel_x, o_result.texel_x);
                        error_count++;
                    end
                    if (o_result.texel_y !== exp_r.texel_y) begin
                        $display("%0t: texel_y expected %0d actual %0d",
                                 $time, exp_r.texel_y, o_result.texel_y);
                        error_count++;
                    end
                    if (o_result.texel_index !== exp_r.texel_index) begin
                        $display("%0t: texel_index expected %0d actual %0d",
                                 $time, exp_r.texel_index, o_result.texel_index);
                        error_count++;
                    end
                    if (o_result.zero_direction !== exp_r.zero_direction) begin
                        $display("%0t: zero_direction expected %0d actual %0d",
                                 $time, exp_r.zero_direction, o_result.zero_direction);
                        error_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                face_size_model = i_cfg_data;
                accepted_now = 1;
            end
            if (start && !busy) begin
                expected_texels.insert(expected_texels.size(),
                                       predict_texel(i_dir, face_size_model));
                accepted_now = 1;
            end
            idle_cycles = accepted_now ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        do @(negedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_dir(input t_dir d);
        start <= 1'b1;
        i_dir <= d;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_with_gap(input t_dir d);
        send_dir(d);
        pause_sender(pick_gap());
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_texels.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_face_size(input logic [FACE_SIZE_W-1:0] v);
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= FACE_SIZE_W'($urandom);
        @(posedge i_clk);
    endtask

    function automatic t_dir make_dir(int x, int y, int z);
        t_dir d;
        d.dir_x = DIR_W'(x);
        d.dir_y = DIR_W'(y);
        d.dir_z = DIR_W'(z);
        return d;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic int signed_of(int magn);
        return $urandom_range(0, 1) ? -magn : magn;
    endfunction

    function automatic t_dir random_dir();
        int v[3];
        int mg, k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                foreach (v[i]) v[i] = int'($urandom_range(0, 65535)) - 32768;
            end
            4, 5: begin
                foreach (v[i]) v[i] = int'($urandom_range(0, 16)) - 8;
            end
            6, 7: begin
                // tied magnitudes on two or three axes
                mg = $urandom_range(0, 1) ? $urandom_range(1, 32767) : $urandom_range(1, 20);
                foreach (v[i]) v[i] = signed_of(mg);
                k = $urandom_range(0, 3);
                if (k < 3) v[k] = signed_of($urandom_range(0, mg - 1));
            end
            8: begin
                foreach (v[i]) v[i] = extreme_value();
            end
            default: begin
                mg = $urandom_range(1, 32767);
                foreach (v[i]) v[i] = signed_of($urandom_range(0, mg));
                v[$urandom_range(0, 2)] = signed_of(mg);
            end
        endcase
        return make_dir(v[0], v[1], v[2]);
    endfunction

    task automatic run_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
            send_with_gap(random_dir());
        end
        burst_mode = 0;
    endtask

    task automatic test_directed_faces();
        send_with_gap(make_dir(0, 0, 0));
        send_with_gap(make_dir(32767, 0, 0));
        send_with_gap(make_dir(-32768, 0, 0));
        send_with_gap(make_dir(0, 32767, 0));
        send_with_gap(make_dir(0, -32768, 0));
        send_with_gap(make_dir(0, 0, 32767));
        send_with_gap(make_dir(0, 0, -32768));
        send_with_gap(make_dir(-32768, -32768, -32768));
        send_with_gap(make_dir(32767, 32767, 32767));
        send_with_gap(make_dir(32767, -32768, 0));
        send_with_gap(make_dir(5, 5, 5));
        send_with_gap(make_dir(-5, 5, -5));
        send_with_gap(make_dir(0, 4, -4));
        send_with_gap(make_dir(0, -4, 4));
        send_with_gap(make_dir(1, 2, 3));
        send_with_gap(make_dir(1, 2, -3));
        send_with_gap(make_dir(100, 100, -100));
        send_with_gap(make_dir(100, -100, 100));
        send_with_gap(make_dir(-1, 0, 0));
        send_with_gap(make_dir(0, 0, -1));
        send_with_gap(make_dir(-32768, 32767, -32767));
        run_random(150);
    endtask

    // size 0 acts as 1, 2047 saturates to the limit
    task automatic test_size_extremes();
        write_face_size(11'd0);
        send_with_gap(make_dir(7, -3, 2));
        run_random(80);
        write_face_size(11'd1);
        run_random(80);
        write_face_size(11'd2047);
        send_with_gap(make_dir(32767, -32768, 32767));
        run_random(120);
        write_face_size(11'd1024);
        send_with_gap(make_dir(-32768, 32767, -32768));
        run_random(120);
        write_face_size(11'd1025);
        run_random(60);
    endtask

    task automatic test_random_sizes();
        logic [FACE_SIZE_W-1:0] sizes[5];
        sizes[0] = 11'd2;
        sizes[1] = 11'd3;
        sizes[2] = FACE_SIZE_W'($urandom_range(1, 1024));
        sizes[3] = FACE_SIZE_W'($urandom_range(1, 2047));
        sizes[4] = 11'd1023;
        foreach (sizes[i]) begin
            write_face_size(sizes[i]);
            run_random(120);
        end
    endtask

    task automatic test_drain_pause();
        write_face_size(11'd256);
        repeat (4) begin
            run_random(25);
            wait_drained();
        end
        burst_mode = 1;
        run_random(60);
        burst_mode = 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_faces();
        test_size_extremes();
        test_random_sizes();
        test_drain_pause();
        wait_drained();
        repeat (DRAIN) @(posedge i_clk);
        if (error_count == 0 && expected_texels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
